### rtl/mbps_pkg.sv
// Package for the masked byte pattern search block.
// Holds the request and result structs, configuration layout and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package mbps_pkg;

  // Default sizing of the pattern window and the byte counter.
  localparam int MAX_PATTERN_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;

  // Fixed field and register widths.
  localparam int BYTE_W         = 8;
  localparam int MATCH_OFFSET_W = 32;
  localparam int PATTERN_BYTES  = 16;
  localparam int HALF_BYTES     = 8;
  localparam int PAT_LEN_W      = 5;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_INDEX_W    = 8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MASK  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 8'd3;

  // Result kinds.
  localparam logic KIND_FOUND     = 1'b0;
  localparam logic KIND_NOT_FOUND = 1'b1;

  // One input request: a byte of the scanned region.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } mbps_in_t;

  // One result.
  typedef struct packed {
    logic                      result_kind;
    logic [MATCH_OFFSET_W-1:0] match_offset;
  } mbps_out_t;

  // Configuration as seen by the search core.
  typedef struct packed {
    logic [PATTERN_BYTES-1:0][BYTE_W-1:0] pattern;
    logic [PATTERN_BYTES-1:0]             wild_mask;
    logic [PAT_LEN_W-1:0]                 pat_len;
  } mbps_cfg_t;

endpackage

### rtl/mbps_cfg.sv
// Configuration register file of the masked byte pattern search block.
// Decodes writes to the pattern, wildcard mask and length registers; uses mbps_pkg.
`timescale 1ns / 1ps

module mbps_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data,
  output mbps_pkg::mbps_cfg_t             cfg
);
  import mbps_pkg::*;

  logic [CFG_DATA_W-1:0]    pat_low_r,  pat_low_nxt;
  logic [CFG_DATA_W-1:0]    pat_high_r, pat_high_nxt;
  logic [PATTERN_BYTES-1:0] mask_r,     mask_nxt;
  logic [PAT_LEN_W-1:0]     len_r,      len_nxt;

  // Write decode; an index past the last register is dropped.
  always_comb begin
    pat_low_nxt  = pat_low_r;
    pat_high_nxt = pat_high_r;
    mask_nxt     = mask_r;
    len_nxt      = len_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LOW:    pat_low_nxt  = cfg_data;
        REG_PATTERN_HIGH:   pat_high_nxt = cfg_data;
        REG_WILDCARD_MASK:  mask_nxt     = cfg_data[PATTERN_BYTES-1:0];
        REG_PATTERN_LENGTH: len_nxt      = cfg_data[PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      mask_r     <= '0;
      len_r      <= PAT_LEN_W'(1);
    end else begin
      pat_low_r  <= pat_low_nxt;
      pat_high_r <= pat_high_nxt;
      mask_r     <= mask_nxt;
      len_r      <= len_nxt;
    end
  end

  // Lay the two pattern words out as one byte array, byte 0 lowest.
  for (genvar i = 0; i < HALF_BYTES; i++) begin : g_pat
    assign cfg.pattern[i]              = pat_low_r[BYTE_W*i +: BYTE_W];
    assign cfg.pattern[i + HALF_BYTES] = pat_high_r[BYTE_W*i +: BYTE_W];
  end
  assign cfg.wild_mask = mask_r;
  assign cfg.pat_len   = len_r;

endmodule

### rtl/mbps_core.sv
// Search core of the masked byte pattern search block: byte window, byte count,
// found flag and the parallel masked compare. Uses mbps_pkg.
`timescale 1ns / 1ps

module mbps_core #(
  parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  mbps_pkg::mbps_in_t   item,
  input  mbps_pkg::mbps_cfg_t  cfg,
  output logic                 res_valid,
  output mbps_pkg::mbps_out_t  res
);
  import mbps_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_r, win_nxt, win_sh;
  logic [OFFSET_BITS-1:0]             seen_r, seen_nxt, seen_inc;
  logic                               done_r, done_nxt;
  logic [LEN_W-1:0]                   act_len;
  logic [LEN_W-1:0]                   age [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]             pos_ok;
  logic [OFFSET_BITS-1:0]             len_ext;
  logic [OFFSET_BITS-1:0]             offset;
  logic                               found;

  // Length in use: zero acts as one, anything past the window as the window.
  always_comb begin
    if (cfg.pat_len == '0) begin
      act_len = LEN_W'(1);
    end else if (cfg.pat_len > PAT_LEN_W'(MAX_PATTERN)) begin
      act_len = LEN_W'(MAX_PATTERN);
    end else begin
      act_len = cfg.pat_len[LEN_W-1:0];
    end
  end

  // Window with the new byte shifted in at age zero.
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_shift
    if (i == 0) begin : g_new
      assign win_sh[i] = item.data_byte;
    end else begin : g_old
      assign win_sh[i] = win_r[i-1];
    end
  end

  // Masked compare: pattern position p lines up with the byte of age n-1-p.
  always_comb begin
    for (int p = 0; p < MAX_PATTERN; p++) begin
      age[p]    = act_len - LEN_W'(1) - LEN_W'(p);
      pos_ok[p] = (LEN_W'(p) >= act_len) || cfg.wild_mask[p] ||
                  (win_sh[age[p][IDX_W-1:0]] == cfg.pattern[p]);
    end
  end

  // Saturating byte count and match offset.
  assign seen_inc = (&seen_r) ? seen_r : seen_r + OFFSET_BITS'(1);
  assign len_ext  = OFFSET_BITS'(act_len);
  assign offset   = seen_inc - len_ext;
  assign found    = (seen_inc >= len_ext) && (&pos_ok);

  // Result for the current request.
  always_comb begin
    res_valid = step && !done_r && (found || item.last_byte);
    if (found) begin
      res.result_kind  = KIND_FOUND;
      res.match_offset = MATCH_OFFSET_W'(offset);
    end else begin
      res.result_kind  = KIND_NOT_FOUND;
      res.match_offset = '0;
    end
  end

  // State update; the last byte of a region clears everything.
  always_comb begin
    win_nxt  = win_r;
    seen_nxt = seen_r;
    done_nxt = done_r;
    if (step) begin
      if (!done_r) begin
        win_nxt  = win_sh;
        seen_nxt = seen_inc;
        done_nxt = found;
      end
      if (item.last_byte) begin
        win_nxt  = '0;
        seen_nxt = '0;
        done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      seen_r <= '0;
      done_r <= 1'b0;
    end else begin
      win_r  <= win_nxt;
      seen_r <= seen_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

### rtl/masked_byte_pattern_search.sv
// Top level of the masked byte pattern search block.
// Input register, search core, result register; uses mbps_pkg, mbps_cfg, mbps_core.
//
//   Channel   Direction  Handshake             Payload
//   in_       request    in_valid / in_ready   mbps_in_t  (data_byte, last_byte)
//   out_      result     out_valid / out_ready mbps_out_t (result_kind, match_offset)
//   cfg_      write      cfg_we                cfg_index, cfg_data
//
// One byte per cycle is sustained while out_ready stays high; a taken request passes
// through the input register, then the window compare into the result register.
// The loop through the byte window and counter holds no register beyond their own.
// Reset is synchronous; no clearing pass is needed.
// While a result waits on out_ready, the input register still holds one more request.
`timescale 1ns / 1ps

module masked_byte_pattern_search #(
  parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mbps_pkg::mbps_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mbps_pkg::mbps_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mbps_pkg::*;

  mbps_in_t  in_r;
  logic      in_vld_r, in_vld_nxt;
  mbps_out_t out_r;
  logic      out_vld_r, out_vld_nxt;
  logic      advance;
  logic      res_valid;
  mbps_out_t res;
  mbps_cfg_t cfg;

  // A held request moves on when the result register is free or being emptied.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // Input register.
  assign in_vld_nxt = in_ready ? in_valid : in_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Configuration registers.
  mbps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Window compare and region state.
  mbps_core #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (in_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register.
  always_comb begin
    if (advance) begin
      out_vld_nxt = res_valid;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // A not-found result never carries an offset.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == KIND_NOT_FOUND) |-> out_data.match_offset == '0)
    else $error("not-found result with nonzero offset");

  // A held request is never stuck behind an empty result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !out_vld_r |-> advance && in_ready)
    else $error("held request not advanced into free result register");

  // No result is presented right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

### verif/masked_byte_pattern_search_checker.sv
// Checker for the masked byte pattern search block: watches the request, result and
// configuration ports, predicts each result and compares it field by field.
// Depends on mbps_pkg for the payload structs, register indexes and result kinds.
`timescale 1ns / 1ps

module masked_byte_pattern_search_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  mbps_pkg::mbps_in_t               in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  mbps_pkg::mbps_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatches,
  output int                               outstanding
);
  import mbps_pkg::*;

  // Shadow copy of the configuration registers.
  logic [PATTERN_BYTES*BYTE_W-1:0] pattern_bits;
  logic [PATTERN_BYTES-1:0]        wild_bits;
  logic [PAT_LEN_W-1:0]            length_reg;

  // Scan state of the current region; recent_bytes[0] is the newest byte.
  logic [BYTE_W-1:0]          recent_bytes [MAX_PATTERN_DEF];
  logic [OFFSET_BITS_DEF-1:0] region_count;
  logic                       region_matched;

  mbps_out_t results_due [$];
  mbps_out_t oldest_due;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_region();
    foreach (recent_bytes[i]) recent_bytes[i] = '0;
    region_count   = '0;
    region_matched = 1'b0;
  endtask

  // Shift one request into the window and queue the result it causes, if any.
  task automatic scan_request(input mbps_in_t req);
    int unsigned span;
    logic        hit;
    mbps_out_t   res;
    if (!region_matched) begin
      // A length of zero behaves as one, anything past the window as the full window.
      span = (length_reg == 0) ? 1 :
             ((length_reg > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : length_reg);
      for (int i = MAX_PATTERN_DEF - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
      recent_bytes[0] = req.data_byte;
      if (region_count != '1) region_count++;
      // Pattern position p lines up with the byte of age span-1-p.
      hit = (region_count >= span);
      for (int p = 0; p < span; p++) begin
        if (!wild_bits[p] && recent_bytes[span-1-p] != pattern_bits[p*BYTE_W +: BYTE_W])
          hit = 1'b0;
      end
      if (hit) begin
        region_matched   = 1'b1;
        res.result_kind  = KIND_FOUND;
        res.match_offset = region_count - span;
        results_due.push_back(res);
      end else if (req.last_byte) begin
        res.result_kind  = KIND_NOT_FOUND;
        res.match_offset = '0;
        results_due.push_back(res);
      end
    end
    if (req.last_byte) clear_region();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pattern_bits = '0;
      wild_bits    = '0;
      length_reg   = 5'd1;
      clear_region();
      results_due.delete();
    end else begin
      // Results are compared before this edge's request is scanned.
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with no request pending", out_data.match_offset, '0);
        end else begin
          oldest_due = results_due.pop_front();
          if (out_data.result_kind !== oldest_due.result_kind)
            report_mismatch("result_kind", out_data.result_kind, oldest_due.result_kind);
          if (out_data.match_offset !== oldest_due.match_offset)
            report_mismatch("match_offset", out_data.match_offset, oldest_due.match_offset);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_LOW:    pattern_bits[0 +: 64]  = cfg_data;
          REG_PATTERN_HIGH:   pattern_bits[64 +: 64] = cfg_data;
          REG_WILDCARD_MASK:  wild_bits  = cfg_data[PATTERN_BYTES-1:0];
          REG_PATTERN_LENGTH: length_reg = cfg_data[PAT_LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) scan_request(in_data);
    end
    outstanding <= results_due.size();
  end

endmodule

### verif/masked_byte_pattern_search_tb.sv
// Testbench top for the masked byte pattern search block: clock, reset, request and
// configuration stimulus, receiver stalls, watchdog and verdict.
// Depends on mbps_pkg, the block and masked_byte_pattern_search_checker.
`timescale 1ns / 1ps

module masked_byte_pattern_search_tb;
  import mbps_pkg::*;

  typedef logic [BYTE_W-1:0] byte_q_t [$];

  localparam int RANDOM_ITEMS = 1550;
  localparam int SETTLE       = 8;
  localparam int STALL_LIMIT  = 2000;

  // Indexes that address no register; writes to them must change nothing.
  localparam logic [CFG_INDEX_W-1:0] IDX_UNUSED_FIRST = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] IDX_UNUSED_LAST  = 8'hFF;

  localparam logic [127:0] DIR_PATTERN = 128'h0F1E2D3C4B5A69788796A5B4C3D200FF;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  mbps_in_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  mbps_out_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  int items_sent  = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_by_phase  [4] = '{0, 55, 0, 29};
  int stall_by_phase [4] = '{0, 0, 55, 29};

  // Configuration currently loaded into the block.
  logic [127:0]             cur_pattern = '0;
  logic [PATTERN_BYTES-1:0] cur_wild    = '0;
  logic [PAT_LEN_W-1:0]     cur_length  = 5'd1;

  masked_byte_pattern_search dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  masked_byte_pattern_search_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver back-pressure.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("masked_byte_pattern_search_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request, idling first at random; valid stays high until accepted.
  task automatic push_byte(input logic [BYTE_W-1:0] value, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: value, last_byte: last};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Hold requests back until every result is in and the pipeline has drained.
  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_pattern(input logic [127:0] pat, input logic [PATTERN_BYTES-1:0] wild,
                              input logic [PAT_LEN_W-1:0] len);
    go_quiet();
    write_reg(REG_PATTERN_LOW, pat[63:0]);
    write_reg(REG_PATTERN_HIGH, pat[127:64]);
    write_reg(REG_WILDCARD_MASK, CFG_DATA_W'(wild));
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
    cur_pattern = pat;
    cur_wild    = wild;
    cur_length  = len;
  endtask

  task automatic send_region(input byte_q_t region);
    foreach (region[i]) push_byte(region[i], i == region.size() - 1);
  endtask

  // Append the first count pattern positions, with random bytes on wildcards.
  task automatic append_pattern(inout byte_q_t region, input int count);
    for (int p = 0; p < count; p++) begin
      if (cur_wild[p]) region.push_back(BYTE_W'($urandom_range(255)));
      else region.push_back(cur_pattern[p*BYTE_W +: BYTE_W]);
    end
  endtask

  // Filler biased toward pattern bytes so that partial matches occur often.
  function automatic logic [BYTE_W-1:0] noise_byte();
    if ($urandom_range(1)) return BYTE_W'($urandom_range(255));
    return cur_pattern[$urandom_range(PATTERN_BYTES-1)*BYTE_W +: BYTE_W];
  endfunction

  task automatic random_pattern();
    logic [127:0]             pat;
    logic [PATTERN_BYTES-1:0] wild;
    logic [PAT_LEN_W-1:0]     len;
    int                       pick;
    pat  = {$urandom, $urandom, $urandom, $urandom};
    wild = PATTERN_BYTES'($urandom & $urandom & $urandom);
    pick = $urandom_range(9);
    if (pick == 0) pat = '0;
    if (pick == 1) pat = '1;
    if (pick == 2) wild = '1;
    if (pick == 3) wild = '0;
    pick = $urandom_range(9);
    case (pick)
      0:       len = 5'd0;
      1:       len = 5'd16;
      2:       len = PAT_LEN_W'($urandom_range(17, 31));
      3:       len = 5'd1;
      default: len = PAT_LEN_W'($urandom_range(1, 16));
    endcase
    load_pattern(pat, wild, len);
  endtask

  // Mostly regions that hold the pattern; some broken, truncated or pure noise.
  task automatic random_region();
    byte_q_t region;
    int      span;
    int      kind;
    int      start;
    int      p;
    span = (cur_length == 0) ? 1 : ((cur_length > 16) ? 16 : cur_length);
    kind = $urandom_range(9);
    repeat ($urandom_range(kind < 2 ? 30 : 12)) region.push_back(noise_byte());
    start = region.size();
    if (kind == 3) begin
      append_pattern(region, $urandom_range(span - 1));
    end else if (kind >= 2) begin
      append_pattern(region, span);
      if (kind == 2) begin
        p = $urandom_range(span - 1);
        if (!cur_wild[p]) region[start+p] ^= BYTE_W'($urandom_range(1, 255));
      end
    end
    if (kind != 3) repeat ($urandom_range(8)) region.push_back(noise_byte());
    if (region.size() == 0) region.push_back(noise_byte());
    send_region(region);
  endtask

  initial begin
    byte_q_t region;
    int      target;
    int      regions_done;
    regions_done = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: a single zero byte matches at once, other bytes never do.
    region = '{8'h00};
    send_region(region);
    region = '{8'hA5, 8'h3C};
    send_region(region);

    // Full-width pattern holding both byte extremes, matched on the last byte.
    load_pattern(DIR_PATTERN, '0, 5'd16);
    region.delete();
    append_pattern(region, 16);
    send_region(region);

    // Overlong length acts as the full window; a short region cannot match.
    load_pattern(DIR_PATTERN, '0, 5'd31);
    region.delete();
    append_pattern(region, 3);
    send_region(region);

    // Zero length acts as one; writes to unused indexes are dropped. The sender
    // also waits for the found result before the ignored last byte.
    load_pattern(DIR_PATTERN, '0, 5'd0);
    write_reg(IDX_UNUSED_FIRST, '1);
    write_reg(IDX_UNUSED_LAST, {$urandom, $urandom});
    push_byte(8'h12, 1'b0);
    push_byte(8'hFF, 1'b0);
    go_quiet();
    push_byte(8'h34, 1'b1);

    // Random regions in four back-pressure phases, with a new pattern now and then.
    target = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_by_phase[phase];
      recv_stall_pct = stall_by_phase[phase];
      target += RANDOM_ITEMS / 4;
      while (items_sent < target) begin
        if (regions_done % 6 == 0) random_pattern();
        random_region();
        regions_done++;
      end
    end

    go_quiet();
    if (mismatches == 0 && outstanding == 0) begin
      $display("masked_byte_pattern_search_tb OK");
    end else begin
      $display("masked_byte_pattern_search_tb NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mbps_pkg.sv
rtl/mbps_cfg.sv
rtl/mbps_core.sv
rtl/masked_byte_pattern_search.sv
verif/masked_byte_pattern_search_checker.sv
verif/masked_byte_pattern_search_tb.sv
